// ===== rtl/core/crc_bd_pkg.sv =====
package crc_bd_pkg;

    localparam int unsigned PAYLOAD_LIMIT  = 4096;
    localparam int unsigned POS_W          = 17;
    localparam int unsigned HEADER_BYTES   = 8;
    localparam int unsigned OVERHEAD_BYTES = 12;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POS_W-1:0] POS_MAX   = {POS_W{1'b1}};
    localparam logic [31:0]      LIMIT_W   = 32'(PAYLOAD_LIMIT);
    localparam logic [31:0]      CRC_POLY  = 32'h04c1_1db7;
    localparam logic [31:0]      CRC_INIT  = 32'hffff_ffff;
    localparam logic [31:0]      CRC_XOUT  = 32'hffff_ffff;

    localparam logic [1:0] VERDICT_OK       = 2'd0;
    localparam logic [1:0] VERDICT_SHORT    = 2'd1;
    localparam logic [1:0] VERDICT_BAD_LEN  = 2'd2;
    localparam logic [1:0] VERDICT_CRC_BAD  = 2'd3;

    // one classified byte travelling from front to back
    typedef struct packed {
        logic [7:0]  body_byte;
        logic        end_of_body;
        logic        is_payload;
        logic        is_trailer;
        logic        emit;
        logic        last;
        logic        too_short;
        logic        bad_length;
        logic [31:0] sequence_word;
        logic [31:0] length_word;
    } t_cmd;

    // crc-32/bzip2 register update over one byte, msb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'h00_0000};
        for (int k = 0; k < 8; k++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crc_bd_front.sv =====
module crc_bd_front
    import crc_bd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_body_byte,
    input  logic       i_end_of_body,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_seq, n_seq;
    logic [31:0]      r_len, n_len;

    logic             in_seq, in_len, in_header, in_payload;
    logic [POS_W-1:0] off;
    logic [31:0]      off_w;
    logic [POS_W:0]   count;
    logic             accept;

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept;

    always_comb begin
        in_seq     = r_pos < POS_W'(4);
        in_len     = !in_seq && (r_pos < POS_W'(HEADER_BYTES));
        in_header  = in_seq || in_len;
        off        = r_pos - POS_W'(HEADER_BYTES);
        off_w      = 32'(off);
        in_payload = !in_header && (off_w < r_len);
        count      = {1'b0, r_pos} + (POS_W+1)'(1);

        n_seq = in_seq ? {r_seq[23:0], i_body_byte} : r_seq;
        n_len = in_len ? {r_len[23:0], i_body_byte} : r_len;

        o_cmd.body_byte     = i_body_byte;
        o_cmd.end_of_body   = i_end_of_body;
        o_cmd.is_payload    = in_payload;
        o_cmd.is_trailer    = !in_header && !in_payload;
        o_cmd.emit          = in_payload && (r_len <= LIMIT_W) && !i_end_of_body;
        o_cmd.last          = (off_w + 32'd1) == r_len;
        o_cmd.too_short     = count < (POS_W+1)'(OVERHEAD_BYTES);
        o_cmd.bad_length    = (n_len > LIMIT_W) ||
                              (33'(count) != (33'(OVERHEAD_BYTES) + {1'b0, n_len}));
        o_cmd.sequence_word = n_seq;
        o_cmd.length_word   = n_len;

        n_pos = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_seq <= '0;
            r_len <= '0;
        end else if (accept) begin
            if (i_end_of_body) begin
                r_pos <= '0;
                r_seq <= '0;
                r_len <= '0;
            end else begin
                r_pos <= n_pos;
                r_seq <= n_seq;
                r_len <= n_len;
            end
        end
    end

endmodule

// ===== rtl/core/crc_bd_queue.sv =====
module crc_bd_queue
    import crc_bd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/crc_bd_back.sv =====
module crc_bd_back
    import crc_bd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_status,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_last,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_block_sequence,
    output logic [31:0] o_payload_length,
    output logic [31:0] o_received_crc
);

    logic [31:0] r_crc, n_crc;
    logic [31:0] r_cw, n_cw;
    logic        r_valid;
    logic        r_is_status;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [1:0]  r_verdict, n_verdict;
    logic [31:0] r_seq, r_len, r_rcrc;

    logic out_free, produces, load;

    assign out_free = !r_valid || i_ready;
    assign produces = i_cmd.end_of_body || i_cmd.emit;
    assign o_pop    = i_cmd_valid && (out_free || !produces);
    assign load     = o_pop && produces;

    always_comb begin
        n_crc = i_cmd.is_payload ? crc_byte(r_crc, i_cmd.body_byte) : r_crc;
        n_cw  = i_cmd.is_trailer ? {r_cw[23:0], i_cmd.body_byte} : r_cw;
        if (i_cmd.too_short) begin
            n_verdict = VERDICT_SHORT;
        end else if (i_cmd.bad_length) begin
            n_verdict = VERDICT_BAD_LEN;
        end else if ((n_crc ^ CRC_XOUT) != n_cw) begin
            n_verdict = VERDICT_CRC_BAD;
        end else begin
            n_verdict = VERDICT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= CRC_INIT;
            r_cw  <= '0;
        end else if (o_pop) begin
            if (i_cmd.end_of_body) begin
                r_crc <= CRC_INIT;
                r_cw  <= '0;
            end else begin
                r_crc <= n_crc;
                r_cw  <= n_cw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_is_status <= i_cmd.end_of_body;
            if (i_cmd.end_of_body) begin
                r_byte    <= '0;
                r_last    <= 1'b0;
                r_verdict <= n_verdict;
                r_seq     <= i_cmd.sequence_word;
                r_len     <= i_cmd.length_word;
                r_rcrc    <= n_cw;
            end else begin
                r_byte    <= i_cmd.body_byte;
                r_last    <= i_cmd.last;
                r_verdict <= VERDICT_OK;
                r_seq     <= '0;
                r_len     <= '0;
                r_rcrc    <= '0;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_is_status      = r_is_status;
    assign o_payload_byte   = r_byte;
    assign o_payload_last   = r_last;
    assign o_verdict        = r_verdict;
    assign o_block_sequence = r_seq;
    assign o_payload_length = r_len;
    assign o_received_crc   = r_rcrc;

endmodule

// ===== rtl/core/crc_block_deframer.sv =====
// Block body checker. Bytes of a body (4-byte sequence number, 4-byte length,
// payload, 4-byte crc-32/bzip2 over the payload, all big-endian) enter one per
// cycle, the final one marked by i_end_of_body. Payload bytes are passed out
// as they arrive when the length field is at most 4096; the final byte gives
// one status transfer with verdict, sequence number, length and received crc.
// A byte is taken every cycle while the 4-entry queue has room; its
// classification is written into the queue when the byte is taken, and the
// crc update and output register load follow when it is popped from the
// queue, so the queue absorbs stalls on the output side.
module crc_block_deframer
    import crc_bd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_body_byte,
    input  logic        i_end_of_body,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_is_status,
    output logic [7:0]  o_payload_byte,
    output logic        o_payload_last,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_block_sequence,
    output logic [31:0] o_payload_length,
    output logic [31:0] o_received_crc
);

    t_cmd push_cmd, head_cmd;
    logic push, queue_full, head_valid, pop;

    crc_bd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_body_byte   (i_body_byte),
        .i_end_of_body (i_end_of_body),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    crc_bd_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (queue_full),
        .i_pop      (pop),
        .o_valid    (head_valid),
        .o_cmd      (head_cmd)
    );

    crc_bd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (head_valid),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_is_status      (o_is_status),
        .o_payload_byte   (o_payload_byte),
        .o_payload_last   (o_payload_last),
        .o_verdict        (o_verdict),
        .o_block_sequence (o_block_sequence),
        .o_payload_length (o_payload_length),
        .o_received_crc   (o_received_crc)
    );

endmodule
